[design/kdc_pkg.sv]
package kdc_pkg;

    localparam int NUM_KEYS = 4;
    localparam int KEY_W    = 2;
    localparam int CFG_W    = 16;
    localparam int IDX_W    = 3;
    localparam int FSM_W    = 7;
    localparam int EVENT_W  = 5;

    // Register indexes on the write port.
    localparam logic [IDX_W-1:0] REG_DEBOUNCE = 3'd0;
    localparam logic [IDX_W-1:0] REG_SCAN_DIV = 3'd1;
    localparam logic [IDX_W-1:0] REG_SHORT    = 3'd2;
    localparam logic [IDX_W-1:0] REG_LONG     = 3'd3;
    localparam logic [IDX_W-1:0] REG_POLARITY = 3'd4;
    localparam logic [IDX_W-1:0] REG_REPORT   = 3'd5;

    localparam logic [7:0]          RST_DEBOUNCE = 8'd3;
    localparam logic [7:0]          RST_SCAN_DIV = 8'd6;
    localparam logic [15:0]         RST_SHORT    = 16'd60;
    localparam logic [15:0]         RST_LONG     = 16'd200;
    localparam logic [NUM_KEYS-1:0] RST_POLARITY = 4'h7;

    // Commands on the input channel.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Event codes.
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_DOWN   = 3'd1;
    localparam logic [2:0] EV_UP     = 3'd2;
    localparam logic [2:0] EV_SINGLE = 3'd3;
    localparam logic [2:0] EV_DOUBLE = 3'd4;
    localparam logic [2:0] EV_LONG   = 3'd5;
    localparam logic [2:0] EV_HOLD   = 3'd6;
    localparam logic [2:0] EV_COMBO  = 3'd7;

    // Per-key machine state codes.
    localparam logic [2:0] KS_IDLE  = 3'd0;
    localparam logic [2:0] KS_DOWN  = 3'd1;
    localparam logic [2:0] KS_UP    = 3'd2;
    localparam logic [2:0] KS_DOWN2 = 3'd3;
    localparam logic [2:0] KS_LONG  = 3'd5;

    localparam logic [NUM_KEYS-1:0] KEY0_MASK  = 4'b0001;
    localparam logic [NUM_KEYS-1:0] COMBO_MASK = 4'b1001;
    localparam logic [15:0]         HOLD_MAX   = 16'hFFFF;
    localparam logic [7:0]          COUNT_MAX  = 8'hFF;

    typedef struct packed {
        logic [7:0]          settle_scans;
        logic [7:0]          scan_divider;
        logic [15:0]         click_gap;
        logic [15:0]         hold_limit;
        logic [NUM_KEYS-1:0] key_polarity;
        logic                report_press_release;
    } kdc_cfg_t;

    typedef struct packed {
        logic             tick_start;
        logic             scan;
        logic             post;
        logic             key_step;
        logic [KEY_W-1:0] key_sel;
        logic             pop_rd;
        logic             pop_cap;
        logic             pop_empty;
    } kdc_cmd_t;

    typedef struct packed {
        logic mod_done;
        logic post_stop;
        logic key_hit;
        logic empty;
    } kdc_stat_t;

endpackage

[design/kdc_in_if.sv]
interface kdc_in_if
    import kdc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                command;
    logic [NUM_KEYS-1:0] raw_keys;

    modport source (output valid, output command, output raw_keys, input ready);
    modport sink (input valid, input command, input raw_keys, output ready);
endinterface

[design/kdc_out_if.sv]
interface kdc_out_if
    import kdc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             event_valid;
    logic [KEY_W-1:0] key_index;
    logic [2:0]       event_code;

    modport source (output valid, output event_valid, output key_index, output event_code,
                    input ready);
    modport sink (input valid, input event_valid, input key_index, input event_code,
                  output ready);
endinterface

[design/kdc_ram.sv]
module kdc_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[design/kdc_mod.sv]
module kdc_mod (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [7:0]  divisor,
    output logic        done,
    output logic        rem_zero
);
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [7:0]  rem_reg, rem_next;
    logic [15:0] dvd_reg, dvd_next;
    logic [8:0]  part1, part2;
    logic [7:0]  rem1, rem2;

    // Two restoring steps per cycle, one dividend bit each.
    always_comb
    begin
        part1 = {rem_reg, dvd_reg[15]};
        rem1  = (part1 >= {1'b0, divisor}) ? 8'(part1 - {1'b0, divisor}) : part1[7:0];
        part2 = {rem1, dvd_reg[14]};
        rem2  = (part2 >= {1'b0, divisor}) ? 8'(part2 - {1'b0, divisor}) : part2[7:0];

        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = rem2;
            dvd_next = {dvd_reg[13:0], 2'b00};
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
    end

    assign done     = done_reg;
    assign rem_zero = (rem_reg == 8'd0);
endmodule

[design/kdc_datapath.sv]
module kdc_datapath
    import kdc_pkg::*;
#(
    parameter int RING_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  kdc_cfg_t            cfg,
    input  kdc_cmd_t            cmd,
    input  logic [NUM_KEYS-1:0] raw_keys,
    output kdc_stat_t           stat,
    output logic                event_valid,
    output logic [KEY_W-1:0]    key_index,
    output logic [2:0]          event_code
);
    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    logic [NUM_KEYS-1:0] raw_reg;
    logic [NUM_KEYS-1:0] stable_reg, stable_next;
    logic [NUM_KEYS-1:0] prev_reg, prev_next;
    logic [NUM_KEYS-1:0] cand_reg, cand_next;
    logic [NUM_KEYS-1:0] trg_reg, trg_next;
    logic [7:0]          dcnt_reg, dcnt_next;
    logic                deb_reg, deb_next;
    logic [15:0]         hold_reg, hold_next;
    logic [FSM_W-1:0]    fsm_reg [NUM_KEYS];
    logic [FSM_W-1:0]    fsm_wr;
    logic                fsm_we, fsm_clr;
    logic [PTR_W-1:0]    wp_reg, wp_next;
    logic [PTR_W-1:0]    rp_reg, rp_next;
    logic                ev_valid_reg;
    logic [KEY_W-1:0]    key_idx_reg;
    logic [2:0]          code_reg;

    logic [15:0]         hold_inc;
    logic [7:0]          divisor;
    logic                mod_done, rem_zero;
    logic [NUM_KEYS-1:0] sample, trg_now;
    logic [7:0]          dcnt_inc;
    logic                skip, long_clamp, combo;

    logic                push;
    logic [EVENT_W-1:0]  push_data;
    logic [EVENT_W-1:0]  ram_rdata;

    logic [NUM_KEYS-1:0] key_on;
    logic [2:0]          st;
    logic [3:0]          rep;
    logic [2:0]          ev;
    logic                is_on, pressed, key_rep;

    assign hold_inc = (hold_reg == HOLD_MAX) ? hold_reg : hold_reg + 16'd1;
    assign divisor  = (cfg.scan_divider == 8'd0) ? 8'd1 : cfg.scan_divider;

    kdc_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.tick_start),
        .dividend (hold_inc),
        .divisor  (divisor),
        .done     (mod_done),
        .rem_zero (rem_zero)
    );

    assign sample     = raw_reg ^ cfg.key_polarity;
    assign dcnt_inc   = (dcnt_reg < COUNT_MAX) ? dcnt_reg + 8'd1 : dcnt_reg;
    assign skip       = !deb_reg && (hold_reg != HOLD_MAX) && !rem_zero;
    assign long_clamp = (hold_reg >= cfg.hold_limit) && (prev_reg == '0);
    assign trg_now    = stable_reg & ~prev_reg;
    assign combo      = (stable_reg == COMBO_MASK) && (trg_now == KEY0_MASK);

    // One key machine, selected by the controller.
    always_comb
    begin
        key_on  = NUM_KEYS'(1) << cmd.key_sel;
        st      = fsm_reg[cmd.key_sel][2:0];
        rep     = fsm_reg[cmd.key_sel][6:3];
        ev      = EV_NONE;
        is_on   = prev_reg[cmd.key_sel];
        pressed = trg_reg[cmd.key_sel] && is_on;
        if (trg_reg != '0 && trg_reg != key_on)
        begin
            st = KS_IDLE;
        end
        unique case (st)
            KS_IDLE:
            begin
                if (pressed)
                begin
                    ev  = EV_DOWN;
                    rep = 4'd1;
                    st  = KS_DOWN;
                end
            end
            KS_DOWN:
            begin
                if (!is_on)
                begin
                    ev = EV_UP;
                    st = KS_UP;
                end
                else if (hold_reg > cfg.hold_limit)
                begin
                    ev = EV_LONG;
                    st = KS_LONG;
                end
            end
            KS_UP:
            begin
                if (pressed)
                begin
                    ev  = EV_DOWN;
                    rep = rep + 4'd1;
                    if (rep == 4'd2)
                    begin
                        st = KS_DOWN2;
                    end
                end
                else if (hold_reg > cfg.click_gap)
                begin
                    st = KS_IDLE;
                    if (rep == 4'd1)
                    begin
                        ev = EV_SINGLE;
                    end
                    else if (rep == 4'd2)
                    begin
                        ev = EV_DOUBLE;
                    end
                end
            end
            KS_DOWN2:
            begin
                if (!is_on)
                begin
                    ev = EV_UP;
                    st = (hold_reg < cfg.click_gap) ? KS_UP : KS_IDLE;
                end
            end
            KS_LONG:
            begin
                if (is_on)
                begin
                    ev = EV_HOLD;
                end
                else
                begin
                    ev = EV_UP;
                    st = KS_IDLE;
                end
            end
            default:
            begin
            end
        endcase
        fsm_wr  = {rep, st};
        key_rep = (ev != EV_NONE) &&
                  !((ev == EV_DOWN || ev == EV_UP) && !cfg.report_press_release);
    end

    always_comb
    begin
        stable_next = stable_reg;
        prev_next   = prev_reg;
        cand_next   = cand_reg;
        trg_next    = trg_reg;
        dcnt_next   = dcnt_reg;
        deb_next    = deb_reg;
        hold_next   = hold_reg;
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        fsm_we      = 1'b0;
        fsm_clr     = 1'b0;
        push        = 1'b0;
        push_data   = '0;

        if (cmd.tick_start)
        begin
            hold_next = hold_inc;
        end

        if (cmd.scan && !skip)
        begin
            if (sample != stable_reg)
            begin
                deb_next = 1'b1;
                if (sample != cand_reg)
                begin
                    cand_next = sample;
                    dcnt_next = '0;
                end
                else if (dcnt_inc >= cfg.settle_scans)
                begin
                    stable_next = sample;
                    dcnt_next   = '0;
                    hold_next   = 16'd1;
                    deb_next    = 1'b0;
                end
                else
                begin
                    dcnt_next = dcnt_inc;
                end
            end
            else
            begin
                dcnt_next = '0;
                cand_next = sample;
            end
        end

        if (cmd.post)
        begin
            if (long_clamp)
            begin
                hold_next = cfg.hold_limit;
            end
            else
            begin
                trg_next  = trg_now;
                prev_next = stable_reg;
                if (combo)
                begin
                    fsm_clr   = 1'b1;
                    push      = 1'b1;
                    push_data = {KEY_W'(0), EV_COMBO};
                end
            end
        end

        if (cmd.key_step)
        begin
            fsm_we = 1'b1;
            if (key_rep)
            begin
                push      = 1'b1;
                push_data = {cmd.key_sel, ev};
            end
        end

        if (push)
        begin
            wp_next = (wp_reg == PTR_LAST) ? '0 : wp_reg + PTR_W'(1);
        end
        if (cmd.pop_rd)
        begin
            rp_next = (rp_reg == PTR_LAST) ? '0 : rp_reg + PTR_W'(1);
        end
    end

    kdc_ram #(
        .WIDTH (EVENT_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (push),
        .waddr (wp_reg),
        .wdata (push_data),
        .re    (cmd.pop_rd),
        .raddr (rp_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg <= '0;
            prev_reg   <= '0;
            cand_reg   <= '0;
            trg_reg    <= '0;
            dcnt_reg   <= '0;
            deb_reg    <= 1'b0;
            hold_reg   <= '0;
            wp_reg     <= '0;
            rp_reg     <= '0;
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                fsm_reg[i] <= '0;
            end
        end
        else
        begin
            stable_reg <= stable_next;
            prev_reg   <= prev_next;
            cand_reg   <= cand_next;
            trg_reg    <= trg_next;
            dcnt_reg   <= dcnt_next;
            deb_reg    <= deb_next;
            hold_reg   <= hold_next;
            wp_reg     <= wp_next;
            rp_reg     <= rp_next;
            if (fsm_clr)
            begin
                for (int i = 0; i < NUM_KEYS; i++)
                begin
                    fsm_reg[i] <= '0;
                end
            end
            else if (fsm_we)
            begin
                fsm_reg[cmd.key_sel] <= fsm_wr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tick_start)
        begin
            raw_reg <= raw_keys;
        end
        if (cmd.pop_empty)
        begin
            ev_valid_reg <= 1'b0;
            key_idx_reg  <= '0;
            code_reg     <= EV_NONE;
        end
        else if (cmd.pop_cap)
        begin
            ev_valid_reg <= 1'b1;
            key_idx_reg  <= ram_rdata[4:3];
            code_reg     <= ram_rdata[2:0];
        end
    end

    assign stat.mod_done  = mod_done;
    assign stat.post_stop = long_clamp || combo;
    assign stat.key_hit   = key_rep;
    assign stat.empty     = (rp_reg == wp_reg);

    assign event_valid = ev_valid_reg;
    assign key_index   = key_idx_reg;
    assign event_code  = code_reg;
endmodule

[design/kdc_ctrl.sv]
module kdc_ctrl
    import kdc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_command,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  kdc_stat_t stat,
    output kdc_cmd_t  cmd
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_SCAN,
        S_POST,
        S_KEY,
        S_CAP,
        S_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic             in_ready_reg, in_ready_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;

    assign accept = in_valid && in_ready_reg;

    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        in_ready_next  = in_ready_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.key_sel    = key_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    in_ready_next = 1'b0;
                    if (in_command == CMD_READ)
                    begin
                        if (stat.empty)
                        begin
                            cmd.pop_empty  = 1'b1;
                            out_valid_next = 1'b1;
                            state_next     = S_OUT;
                        end
                        else
                        begin
                            cmd.pop_rd = 1'b1;
                            state_next = S_CAP;
                        end
                    end
                    else
                    begin
                        cmd.tick_start = 1'b1;
                        state_next     = S_MOD;
                    end
                end
            end
            S_MOD:
            begin
                if (stat.mod_done)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan   = 1'b1;
                state_next = S_POST;
            end
            S_POST:
            begin
                cmd.post = 1'b1;
                key_next = '0;
                if (stat.post_stop)
                begin
                    in_ready_next = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    state_next = S_KEY;
                end
            end
            S_KEY:
            begin
                cmd.key_step = 1'b1;
                if (stat.key_hit || key_reg == KEY_W'(NUM_KEYS - 1))
                begin
                    in_ready_next = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    key_next = key_reg + KEY_W'(1);
                end
            end
            S_CAP:
            begin
                cmd.pop_cap    = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    in_ready_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            key_reg       <= '0;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            key_reg       <= key_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;
endmodule

[design/key_debounce_click_detector_unit.sv]
// Channel   Dir  Payload                                   Beat when
// req       in   command, raw_keys                         req.valid && req.ready
// rsp       out  event_valid, key_index, event_code        rsp.valid && rsp.ready
// wr_*      in   wr_index, wr_data                         wr_en high
//
// One beat at a time. A tick is accepted, runs through the two-bit-per-cycle
// remainder unit, a scan and a post-scan check, then, unless that check stops
// it, walks the key machines in order (up to four) until one reports an event.
// A read pops the ring into the output register, or clears it on an empty ring.
// Reset clears all control state; ring contents stay unknown until written.
// A stalled result holds in the output register; req.ready stays low until taken.
module key_debounce_click_detector_unit
    import kdc_pkg::*;
#(
    parameter int RING_DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    kdc_in_if.sink           req,
    kdc_out_if.source        rsp,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0] wr_data
);
    kdc_cfg_t  cfg_reg;
    kdc_cmd_t  cmd;
    kdc_stat_t stat;

    // Configuration registers; write them only while no beat is in flight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_scans         <= RST_DEBOUNCE;
            cfg_reg.scan_divider         <= RST_SCAN_DIV;
            cfg_reg.click_gap            <= RST_SHORT;
            cfg_reg.hold_limit           <= RST_LONG;
            cfg_reg.key_polarity         <= RST_POLARITY;
            cfg_reg.report_press_release <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_DEBOUNCE: cfg_reg.settle_scans         <= wr_data[7:0];
                REG_SCAN_DIV: cfg_reg.scan_divider         <= wr_data[7:0];
                REG_SHORT:    cfg_reg.click_gap            <= wr_data;
                REG_LONG:     cfg_reg.hold_limit           <= wr_data;
                REG_POLARITY: cfg_reg.key_polarity         <= wr_data[NUM_KEYS-1:0];
                REG_REPORT:   cfg_reg.report_press_release <= wr_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequence the tick and read steps.
    kdc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_command (req.command),
        .in_ready   (req.ready),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // Debounce, key machines, event ring and output register.
    kdc_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .cmd         (cmd),
        .raw_keys    (req.raw_keys),
        .stat        (stat),
        .event_valid (rsp.event_valid),
        .key_index   (rsp.key_index),
        .event_code  (rsp.event_code)
    );

    // Never take a new beat while a result waits.
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && rsp.valid))
        else $error("req.ready high while rsp.valid pending");

    // An empty read returns all-zero fields.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.event_valid) |-> (rsp.key_index == '0 && rsp.event_code == EV_NONE))
        else $error("empty read with nonzero fields");

    // A popped event always carries a real code.
    a_code_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.event_valid) |-> (rsp.event_code != EV_NONE))
        else $error("popped event with null code");

    // The post-scan check only ever follows a scan step.
    a_tick_seq: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.post |-> $past(cmd.scan))
        else $error("post-scan step without scan");
endmodule

[verif/key_debounce_click_detector_unit_test.sv]
`timescale 1ns / 1ps

module key_debounce_click_detector_unit_test;
    import kdc_pkg::*;

    typedef struct packed {
        logic       event_valid;
        logic [1:0] key_index;
        logic [2:0] event_code;
    } evt_beat_t;

    // One line of the directed script: a command repeated reps times.
    // Where has_event is set, the read is checked against the typed-in event.
    typedef struct packed {
        logic       command;
        logic [3:0] raw_keys;
        logic [9:0] reps;
        logic       has_event;
        evt_beat_t  event_typed;
    } script_row_t;

    typedef struct packed {
        logic [7:0]  settle_scans;
        logic [7:0]  scan_divider;
        logic [15:0] click_gap;
        logic [15:0] hold_limit;
        logic [3:0]  key_polarity;
        logic        report_press_release;
    } key_setup_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [IDX_W-1:0] wr_index;
    logic [CFG_W-1:0] wr_data;

    kdc_in_if  req ();
    kdc_out_if rsp ();

    key_debounce_click_detector_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req.sink),
        .rsp      (rsp.source),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Clock: 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Key scanner model: configuration, debounce state, key machines and
    // the event ring, kept at the block's widths.
    // ------------------------------------------------------------------
    key_setup_t  setup;
    logic [3:0]  stable_set;
    logic [3:0]  last_stable;
    logic [3:0]  candidate_set;
    logic [7:0]  bounce_count;
    logic        settling;
    logic [15:0] held_ticks;
    logic [2:0]  key_state [4];
    logic [3:0]  click_count [4];
    logic [4:0]  event_ring [16];
    logic [3:0]  ring_wr;
    logic [3:0]  ring_rd;

    evt_beat_t  events_due [$];
    int         failures;
    bit         calm;
    int         beats_sent;

    function automatic void store_event(logic [1:0] key, logic [2:0] code);
        event_ring[ring_wr] = {key, code};
        ring_wr = ring_wr + 4'd1;
    endfunction

    // Debounce one raw sample into the stable key set.
    function automatic void debounce_sample(logic [3:0] raw);
        logic [15:0] divisor;
        logic [3:0]  sample;
        divisor = (setup.scan_divider == 8'd0) ? 16'd1 : {8'd0, setup.scan_divider};
        if (held_ticks != HOLD_MAX)
            held_ticks = held_ticks + 16'd1;
        // Between changes only every scan_divider-th tick is looked at.
        if (!settling && held_ticks != HOLD_MAX && (held_ticks % divisor) != 16'd0)
            return;
        sample = raw ^ setup.key_polarity;
        if (sample != stable_set)
        begin
            settling = 1'b1;
            if (sample != candidate_set)
            begin
                candidate_set = sample;
                bounce_count  = 8'd0;
            end
            else
            begin
                if (bounce_count != COUNT_MAX)
                    bounce_count = bounce_count + 8'd1;
                if (bounce_count >= setup.settle_scans)
                begin
                    stable_set   = sample;
                    bounce_count = 8'd0;
                    held_ticks   = 16'd1;
                    settling     = 1'b0;
                end
            end
        end
        else
        begin
            // Bounce back: clear the count but stay in settling.
            bounce_count  = 8'd0;
            candidate_set = sample;
        end
    endfunction

    // Advance one key machine; return the event it reports, if any.
    function automatic logic [2:0] advance_key(int k, logic [3:0] trigger);
        logic [3:0] key_bit;
        logic [2:0] st;
        logic [3:0] reps;
        logic [2:0] code;
        logic       is_on;
        logic       pressed;
        key_bit = 4'b0001 << k;
        st      = key_state[k];
        reps    = click_count[k];
        code    = EV_NONE;
        is_on   = (last_stable & key_bit) != 4'd0;
        pressed = ((trigger & key_bit) != 4'd0) && is_on;
        // A fresh press elsewhere cancels whatever this key was doing.
        if (trigger != 4'd0 && trigger != key_bit)
            st = KS_IDLE;
        case (st)
            KS_IDLE:
            begin
                if (pressed)
                begin
                    code = EV_DOWN;
                    reps = 4'd1;
                    st   = KS_DOWN;
                end
            end
            KS_DOWN:
            begin
                if (!is_on)
                begin
                    code = EV_UP;
                    st   = KS_UP;
                end
                else if (held_ticks > setup.hold_limit)
                begin
                    code = EV_LONG;
                    st   = KS_LONG;
                end
            end
            KS_UP:
            begin
                if (pressed)
                begin
                    code = EV_DOWN;
                    reps = reps + 4'd1;
                    if (reps == 4'd2)
                        st = KS_DOWN2;
                end
                else if (held_ticks > setup.click_gap)
                begin
                    st = KS_IDLE;
                    if (reps == 4'd1)
                        code = EV_SINGLE;
                    else if (reps == 4'd2)
                        code = EV_DOUBLE;
                end
            end
            KS_DOWN2:
            begin
                if (!is_on)
                begin
                    code = EV_UP;
                    st   = (held_ticks < setup.click_gap) ? KS_UP : KS_IDLE;
                end
            end
            KS_LONG:
            begin
                if (is_on)
                    code = EV_HOLD;
                else
                begin
                    code = EV_UP;
                    st   = KS_IDLE;
                end
            end
            default: ;
        endcase
        key_state[k]   = st;
        click_count[k] = reps;
        // Plain down/up events are filtered unless reporting is on.
        if (code == EV_NONE || (code <= EV_UP && !setup.report_press_release))
            return EV_NONE;
        return code;
    endfunction

    function automatic void tick_scanner(logic [3:0] raw);
        logic [3:0] trigger;
        logic [2:0] code;
        debounce_sample(raw);
        // Nothing held past the hold limit: clamp the timer and skip the key machines.
        if (held_ticks >= setup.hold_limit && last_stable == 4'd0)
        begin
            held_ticks = setup.hold_limit;
            return;
        end
        trigger     = stable_set & ~last_stable;
        last_stable = stable_set;
        if (last_stable == COMBO_MASK && trigger == KEY0_MASK)
        begin
            for (int k = 0; k < 4; k++)
            begin
                key_state[k]   = KS_IDLE;
                click_count[k] = 4'd0;
            end
            store_event(2'd0, EV_COMBO);
            return;
        end
        // First key with an event ends the walk.
        for (int k = 0; k < 4; k++)
        begin
            code = advance_key(k, trigger);
            if (code != EV_NONE)
            begin
                store_event(k[1:0], code);
                break;
            end
        end
    endfunction

    function automatic evt_beat_t pop_event();
        evt_beat_t ev;
        ev = '0;
        if (ring_rd != ring_wr)
        begin
            ev.event_valid = 1'b1;
            ev.key_index   = event_ring[ring_rd][4:3];
            ev.event_code  = event_ring[ring_rd][2:0];
            ring_rd        = ring_rd + 4'd1;
        end
        return ev;
    endfunction

    // ------------------------------------------------------------------
    // Request side: drive one beat, idle at random unless calm.
    // ------------------------------------------------------------------
    task automatic send_beat(logic command, logic [3:0] raw, bit has_event, evt_beat_t typed);
        evt_beat_t ev;
        while (!calm && $urandom_range(99) < 30)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid    <= 1'b1;
        req.command  <= command;
        req.raw_keys <= raw;
        do
            @(posedge clk);
        while (!req.ready);
        // Beat accepted at this edge: update the model.
        beats_sent++;
        if (command == CMD_READ)
        begin
            ev = pop_event();
            events_due.push_back(has_event ? typed : ev);
        end
        else
            tick_scanner(raw);
    endtask

    task automatic send_tick(logic [3:0] raw);
        send_beat(CMD_TICK, raw, 1'b0, '0);
    endtask

    task automatic send_read();
        send_beat(CMD_READ, 4'($urandom_range(15)), 1'b0, '0);
    endtask

    // Drop valid, drain all results, then let an in-flight tick finish.
    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (events_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_setup(key_setup_t s);
        logic [CFG_W-1:0] values [6];
        logic [IDX_W-1:0] regs [6];
        regs   = '{REG_DEBOUNCE, REG_SCAN_DIV, REG_SHORT, REG_LONG, REG_POLARITY, REG_REPORT};
        values = '{16'(s.settle_scans), 16'(s.scan_divider), s.click_gap, s.hold_limit,
                   16'(s.key_polarity), 16'(s.report_press_release)};
        for (int i = 0; i < 6; i++)
        begin
            wr_en    <= 1'b1;
            wr_index <= regs[i];
            wr_data  <= values[i];
            @(posedge clk);
        end
        wr_en <= 1'b0;
        setup = s;
    endtask

    // Random phase: mostly held key patterns long enough to debounce, with
    // glitches, long holds and reads mixed in.
    task automatic random_phase(int beats);
        int stop_at;
        int base;
        int span;
        int pick;
        logic [3:0] logical;
        stop_at = beats_sent + beats;
        base    = setup.settle_scans + setup.scan_divider + 1;
        while (beats_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
                logical = 4'd0;
            else if (pick < 75)
                logical = 4'b0001 << $urandom_range(3);
            else if (pick < 85)
                logical = ($urandom_range(1)) ? COMBO_MASK : 4'b1000;
            else
                logical = 4'($urandom_range(15));
            pick = $urandom_range(99);
            if (pick < 15)
                span = $urandom_range(1, setup.settle_scans);
            else if (pick < 85)
                span = base + $urandom_range((setup.click_gap > 40) ? 40 : setup.click_gap);
            else
                span = base + $urandom_range((setup.hold_limit > 300) ? 300 : setup.hold_limit + 5);
            for (int t = 0; t < span && beats_sent < stop_at; t++)
            begin
                if ($urandom_range(99) < 18)
                    send_read();
                // Occasionally flip one line for a single tick as noise.
                if ($urandom_range(99) < 4)
                    send_tick((logical ^ setup.key_polarity) ^ (4'b0001 << $urandom_range(3)));
                else
                    send_tick(logical ^ setup.key_polarity);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Response side: random backpressure and the event checker.
    // ------------------------------------------------------------------
    always @(posedge clk)
        rsp.ready <= calm || ($urandom_range(99) >= 30);

    always @(posedge clk)
    begin
        evt_beat_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (events_due.size() == 0)
            begin
                $error("unexpected event beat: event_valid=%0d key_index=%0d event_code=%0d",
                       rsp.event_valid, rsp.key_index, rsp.event_code);
                failures++;
            end
            else
            begin
                want = events_due.pop_front();
                if (rsp.event_valid !== want.event_valid)
                begin
                    $error("event_valid: expected %0d, got %0d", want.event_valid,
                           rsp.event_valid);
                    failures++;
                end
                if (rsp.key_index !== want.key_index)
                begin
                    $error("key_index: expected %0d, got %0d", want.key_index, rsp.key_index);
                    failures++;
                end
                if (rsp.event_code !== want.event_code)
                begin
                    $error("event_code: expected %0d, got %0d", want.event_code,
                           rsp.event_code);
                    failures++;
                end
            end
        end
    end

    // Directed script under reset settings (polarity 0111: keys 0-2 active
    // low, WKUP active high). Raw 0111 is all released.
    script_row_t script [17] = '{
        '{CMD_READ, 4'b0111, 10'd1,  1'b1, '{1'b0, 2'd0, EV_NONE}},   // empty ring
        '{CMD_TICK, 4'b0111, 10'd10, 1'b0, '0},
        '{CMD_TICK, 4'b1111, 10'd14, 1'b0, '0},                       // WKUP down
        '{CMD_TICK, 4'b1110, 10'd14, 1'b0, '0},                       // then KEY0
        '{CMD_READ, 4'b0000, 10'd1,  1'b1, '{1'b1, 2'd0, EV_COMBO}},  // combo on KEY0
        '{CMD_TICK, 4'b0111, 10'd14, 1'b0, '0},
        '{CMD_READ, 4'b1111, 10'd1,  1'b1, '{1'b0, 2'd0, EV_NONE}},
        '{CMD_TICK, 4'b0110, 10'd14, 1'b0, '0},                       // single click
        '{CMD_TICK, 4'b0111, 10'd80, 1'b0, '0},
        '{CMD_TICK, 4'b0101, 10'd14, 1'b0, '0},                       // double click
        '{CMD_TICK, 4'b0111, 10'd14, 1'b0, '0},
        '{CMD_TICK, 4'b0101, 10'd14, 1'b0, '0},
        '{CMD_TICK, 4'b0111, 10'd80, 1'b0, '0},
        '{CMD_TICK, 4'b0011, 10'd230, 1'b0, '0},                      // long press, hold
        '{CMD_TICK, 4'b1000, 10'd20, 1'b0, '0},                       // all lines flipped
        '{CMD_TICK, 4'b0111, 10'd20, 1'b0, '0},
        '{CMD_READ, 4'b0000, 10'd8,  1'b0, '0}
    };

    key_setup_t phases [6] = '{
        '{8'd1,   8'd1,   16'd8,     16'd20,    4'h0, 1'b1},
        '{8'd2,   8'd3,   16'd15,    16'd40,    4'hF, 1'b1},
        '{8'd255, 8'd255, 16'd65535, 16'd65535, 4'h5, 1'b0},
        '{8'd1,   8'd255, 16'd1,     16'd1,     4'hA, 1'b1},
        '{8'd3,   8'd2,   16'd30,    16'd12,    4'h7, 1'b0},
        '{8'd1,   8'd1,   16'd5,     16'd65535, 4'h3, 1'b1}
    };

    initial
    begin
        failures     = 0;
        beats_sent   = 0;
        calm         = 1'b0;
        rst_n        <= 1'b0;
        wr_en        <= 1'b0;
        wr_index     <= REG_DEBOUNCE;
        wr_data      <= '0;
        req.valid    <= 1'b0;
        req.command  <= CMD_TICK;
        req.raw_keys <= '0;
        setup         = '{RST_DEBOUNCE, RST_SCAN_DIV, RST_SHORT, RST_LONG, RST_POLARITY, 1'b0};
        stable_set    = '0;
        last_stable   = '0;
        candidate_set = '0;
        bounce_count  = '0;
        settling      = 1'b0;
        held_ticks    = '0;
        ring_wr       = '0;
        ring_rd       = '0;
        for (int k = 0; k < 4; k++)
        begin
            key_state[k]   = KS_IDLE;
            click_count[k] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[r])
            for (int i = 0; i < script[r].reps; i++)
                send_beat(script[r].command, script[r].raw_keys, script[r].has_event,
                          script[r].event_typed);
        drain();

        foreach (phases[p])
        begin
            write_setup(phases[p]);
            calm = (p == 1);
            random_phase((p == 2) ? 100 : 120);
            drain();
        end
        calm = 1'b0;

        if (failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hang guard.
    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
design/kdc_pkg.sv
design/kdc_in_if.sv
design/kdc_out_if.sv
design/kdc_ram.sv
design/kdc_mod.sv
design/kdc_datapath.sv
design/kdc_ctrl.sv
design/key_debounce_click_detector_unit.sv
verif/key_debounce_click_detector_unit_test.sv
